// ----- hw/rtl/pthe_pkg.sv -----
package pthe_pkg;

    // Field widths
    localparam int TAG_W     = 32;
    localparam int CNT_W     = 24;
    localparam int COUNT_W   = 16;
    localparam int SECS_W    = 5;
    localparam int BOARD_FW  = 2;
    localparam int SLOT_FW   = 4;

    // One second of tag time is 0x1000 ticks
    localparam int ONE_SECOND_LOG2 = 12;

    // Saturation value of the per-board event counter
    localparam logic [CNT_W-1:0] COUNTER_MAX = 24'hFF_FFFF;

    // Item commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_EVENT = 1'b1;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                cmd;
        logic [BOARD_FW-1:0] board;
        logic [SLOT_FW-1:0]  slot;
        logic [COUNT_W-1:0]  slot_count;
        logic [TAG_W-1:0]    tag;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- hw/rtl/pthe_if.sv -----
interface pthe_in_if import pthe_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [BOARD_FW-1:0] board;
    logic [SLOT_FW-1:0]  slot;
    logic [COUNT_W-1:0]  slot_count;
    logic [TAG_W-1:0]    tag;

    modport source (output valid, cmd, board, slot, slot_count, tag, input ready);
    modport sink   (input valid, cmd, board, slot, slot_count, tag, output ready);
endinterface

interface pthe_out_if import pthe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TAG_W-1:0]  refined_tag;
    logic [SECS_W-1:0] seconds_passed;

    modport source (output valid, refined_tag, seconds_passed, input ready);
    modport sink   (input valid, refined_tag, seconds_passed, output ready);
endinterface

// ----- hw/rtl/pthe_ram.sv -----
module pthe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/pthe_front.sv -----
module pthe_front import pthe_pkg::*; #(
    parameter int NUM_BOARDS  = 4,
    parameter int TABLE_SLOTS = 16
) (
    pthe_in_if.sink i_in,
    input  logic    i_full,
    output logic    o_push,
    output t_op     o_push_op
);

    logic accept;
    logic keep;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    // Loads outside the table and events from absent boards are dropped here
    always_comb begin
        if (i_in.cmd == CMD_LOAD) begin
            keep = (int'(i_in.slot) < TABLE_SLOTS);
        end else begin
            keep = (int'(i_in.board) < NUM_BOARDS);
        end
    end

    assign o_push = accept && keep;

    assign o_push_op.cmd        = i_in.cmd;
    assign o_push_op.board      = i_in.board;
    assign o_push_op.slot       = i_in.slot;
    assign o_push_op.slot_count = i_in.slot_count;
    assign o_push_op.tag        = i_in.tag;

endmodule

// ----- hw/rtl/pthe_queue.sv -----
module pthe_queue import pthe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_op       i_push_op,
    input  logic      i_pop,
    output t_op       o_head,
    output t_q_status o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_op              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [FILL_W-1:0] r_fill, n_fill;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (int'(p) == QUEUE_DEPTH - 1) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_fill = r_fill;
        if (i_push) begin
            n_wptr = ptr_inc(r_wptr);
        end
        if (i_pop) begin
            n_rptr = ptr_inc(r_rptr);
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_op;
        end
    end

    assign o_head         = r_mem[r_rptr];
    assign o_status.full  = (int'(r_fill) == QUEUE_DEPTH);
    assign o_status.empty = (r_fill == '0);

endmodule

// ----- hw/rtl/pthe_back.sv -----
module pthe_back import pthe_pkg::*; #(
    parameter int NUM_BOARDS  = 4,
    parameter int TABLE_SLOTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_op        i_head,
    input  t_q_status  i_q_status,
    output logic       o_pop,
    pthe_out_if.source o_out
);

    localparam int SLOT_AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int SECS_IW = $clog2(TABLE_SLOTS + 1);
    localparam int BOARD_W = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]         r_state, n_state;
    t_op                r_op, n_op;
    logic [BOARD_W-1:0] r_board, n_board;
    logic [CNT_W-1:0]   r_left, n_left;
    logic [SECS_IW-1:0] r_secs, n_secs;
    logic [TAG_W-1:0]   r_res_tag, n_res_tag;
    logic [SECS_W-1:0]  r_res_secs, n_res_secs;
    logic               r_out_valid, n_out_valid;
    logic [TAG_W-1:0]   r_out_tag, n_out_tag;
    logic [SECS_W-1:0]  r_out_secs, n_out_secs;

    logic [TABLE_SLOTS-1:0] r_tab_valid, n_tab_valid;
    logic [CNT_W-1:0]       r_counter [NUM_BOARDS];
    logic [CNT_W-1:0]       n_counter [NUM_BOARDS];
    logic [TAG_W-1:0]       r_last_tag [NUM_BOARDS];
    logic [TAG_W-1:0]       n_last_tag [NUM_BOARDS];
    logic [NUM_BOARDS-1:0]  r_first, n_first;

    logic               ram_we;
    logic [SLOT_AW-1:0] ram_waddr;
    logic               ram_re;
    logic [SLOT_AW-1:0] ram_raddr;
    logic [COUNT_W-1:0] ram_rdata;

    logic               slot_done;
    logic [COUNT_W-1:0] tab_data;
    logic               go_on;
    logic [BOARD_W-1:0] head_board;
    logic [CNT_W-1:0]   base_cnt;

    // table writes happen only at the pop of a load, so the data comes from the head
    pthe_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_head.slot_count),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign head_board = BOARD_W'(i_head.board);

    // r_secs is the slot whose data the RAM shows this cycle; unwritten slots read as zero
    assign slot_done = (int'(r_secs) == TABLE_SLOTS);
    assign tab_data  = (!slot_done && r_tab_valid[r_secs[SLOT_AW-1:0]]) ? ram_rdata : '0;
    assign go_on     = !slot_done && (r_left > CNT_W'(tab_data));
    assign base_cnt  = (r_op.tag != r_last_tag[r_board]) ? '0 : r_counter[r_board];

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_board     = r_board;
        n_left      = r_left;
        n_secs      = r_secs;
        n_res_tag   = r_res_tag;
        n_res_secs  = r_res_secs;
        n_out_valid = r_out_valid;
        n_out_tag   = r_out_tag;
        n_out_secs  = r_out_secs;
        n_tab_valid = r_tab_valid;
        n_counter   = r_counter;
        n_last_tag  = r_last_tag;
        n_first     = r_first;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = SLOT_AW'(r_op.slot);
        ram_re      = 1'b0;
        ram_raddr   = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_op    = i_head;
                    n_board = head_board;
                    if (i_head.cmd == CMD_LOAD) begin
                        ram_we                 = 1'b1;
                        ram_waddr              = SLOT_AW'(i_head.slot);
                        n_tab_valid[ram_waddr] = 1'b1;
                    end else if (r_first[head_board]) begin
                        n_first[head_board] = 1'b0;
                        n_res_tag           = i_head.tag;
                        n_res_secs          = '0;
                        n_state             = ST_FINISH;
                    end else begin
                        n_left  = r_counter[head_board];
                        n_secs  = '0;
                        ram_re  = 1'b1;
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (go_on) begin
                    n_left    = r_left - CNT_W'(tab_data);
                    n_secs    = r_secs + 1'b1;
                    ram_re    = (int'(r_secs) + 1 < TABLE_SLOTS);
                    ram_raddr = SLOT_AW'(r_secs + 1'b1);
                end else begin
                    n_counter[r_board]  = (base_cnt == COUNTER_MAX) ? base_cnt
                                                                    : base_cnt + 1'b1;
                    n_last_tag[r_board] = r_op.tag;
                    n_res_tag  = r_op.tag + (TAG_W'(r_secs) << ONE_SECOND_LOG2);
                    n_res_secs = SECS_W'(r_secs);
                    n_state    = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_tag   = r_res_tag;
                    n_out_secs  = r_res_secs;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_tab_valid <= '0;
            r_first     <= '1;
            for (int b = 0; b < NUM_BOARDS; b++) begin
                r_counter[b]  <= '0;
                r_last_tag[b] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_tab_valid <= n_tab_valid;
            r_first     <= n_first;
            r_counter   <= n_counter;
            r_last_tag  <= n_last_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_board    <= n_board;
        r_left     <= n_left;
        r_secs     <= n_secs;
        r_res_tag  <= n_res_tag;
        r_res_secs <= n_res_secs;
        r_out_tag  <= n_out_tag;
        r_out_secs <= n_out_secs;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.refined_tag    = r_out_tag;
    assign o_out.seconds_passed = r_out_secs;

endmodule

// ----- hw/rtl/packet_time_histogram_expander_top.sv -----
// Packet time tag refiner. Load items (cmd 0) write one per-second event count into a
// table of TABLE_SLOTS slots; event items (cmd 1) return the tag advanced by 0x1000 for
// every table slot the board's event counter passes, and give one result transfer each.
// Loads give no result, and loads to slots past the table or events from boards at or
// beyond NUM_BOARDS are taken and dropped. A front end classifies items and places them
// in a two-entry queue, so the input keeps taking transfers while the queue is not full,
// also while the back end works and while a result waits in the output register. The
// back end runs one item at a time: a load is written as it is popped, a board's first
// event returns its own tag with no walk, and any later event first walks the count
// table, passing k slots (at most TABLE_SLOTS), one slot per cycle through its single
// read port. Table slots never loaded since reset read as zero; no clearing pass is
// needed after reset.
module packet_time_histogram_expander_top import pthe_pkg::*; #(
    parameter int NUM_BOARDS  = 4,
    parameter int TABLE_SLOTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pthe_in_if.sink    i_in,
    pthe_out_if.source o_out
);

    // front -> queue
    logic      push;
    t_op       push_op;
    // queue -> back
    t_op       head;
    t_q_status q_status;
    logic      pop;

    // Front: handshake and range classification
    pthe_front #(
        .NUM_BOARDS  (NUM_BOARDS),
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_front (
        .i_in      (i_in),
        .i_full    (q_status.full),
        .o_push    (push),
        .o_push_op (push_op)
    );

    // Decoupling queue, keeps item order for loads and events alike
    pthe_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .i_pop     (pop),
        .o_head    (head),
        .o_status  (q_status)
    );

    // Back: table writes, per-board state, slot walk and result register
    pthe_back #(
        .NUM_BOARDS  (NUM_BOARDS),
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out      (o_out)
    );

`ifndef ASSERT_OFF
    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("queue overflow");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("queue underflow");

    // status flags stay consistent
    a_status_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty at once");
`endif

endmodule
